// ===== hw/rtl/grid_bitmap_find_next_set_macros.svh =====
`ifndef GRID_BITMAP_FIND_NEXT_SET_MACROS_SVH
`define GRID_BITMAP_FIND_NEXT_SET_MACROS_SVH

// Checks that a condition holds in the same cycle as its antecedent.
`define GBFNS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a condition holds in the cycle after its antecedent.
`define GBFNS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/gbfns_pkg.sv =====
`default_nettype none

package gbfns_pkg;

    localparam int WORD_BITS     = 32;
    localparam int MAX_ROW_WORDS = 4;
    localparam int MAX_ROWS      = 32;
    localparam int DEPTH         = MAX_ROW_WORDS * MAX_ROWS;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int OFF_W  = $clog2(WORD_BITS);
    localparam int WIR_W  = (MAX_ROW_WORDS > 1) ? $clog2(MAX_ROW_WORDS) : 1;

    // Field and register widths.
    localparam int REQ_W      = 3;
    localparam int COL_W      = 7;
    localparam int ROW_W      = 5;
    localparam int RW_W       = 3;
    localparam int RC_W       = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;
    localparam int COLW_W     = COL_W - OFF_W;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_WORDS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 1'b1;

    localparam logic [RW_W-1:0] ROW_WORDS_RESET = 3'd2;
    localparam logic [RC_W-1:0] ROW_COUNT_RESET = 6'd25;

    typedef enum logic [REQ_W-1:0] {
        REQ_CLEAR_ALL  = 3'd0,
        REQ_SET_BIT    = 3'd1,
        REQ_CLEAR_BIT  = 3'd2,
        REQ_TEST_BIT   = 3'd3,
        REQ_FIND_NEXT  = 3'd4,
        REQ_FIND_FIRST = 3'd5
    } req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RMW,
        ST_SCAN,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic             hit;
        logic [COL_W-1:0] found_col;
        logic [ROW_W-1:0] found_row;
        logic             at_end;
    } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/gbfns_ram.sv =====
`default_nettype none

module gbfns_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/grid_bitmap_find_next_set.sv =====
// Set, clear and test read the word when accepted, then write it or answer in ST_RMW.
// Clear all, unused requests and positions outside the map finish in the accept cycle.
// A find reads one word at a time, up to row_count * row_words words, as the bitmap
// memory has a single read port. The result is registered.
// Reset restores row_words to 2 and row_count to 25 and clears every word's valid flag
// at once; a word whose flag is clear reads as zero, so no clearing sweep is needed.
`default_nettype none
`include "grid_bitmap_find_next_set_macros.svh"

module grid_bitmap_find_next_set (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [gbfns_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gbfns_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [gbfns_pkg::REQ_W-1:0]      s_req_type,
    input  logic [gbfns_pkg::COL_W-1:0]      s_col,
    input  logic [gbfns_pkg::ROW_W-1:0]      s_row,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_hit,
    output logic [gbfns_pkg::COL_W-1:0]      m_found_col,
    output logic [gbfns_pkg::ROW_W-1:0]      m_found_row,
    output logic                             m_at_end
);

    import gbfns_pkg::*;

    function automatic logic [ADDR_W-1:0] word_addr(
        input logic [ROW_W-1:0] r,
        input logic [WIR_W-1:0] w,
        input logic [RW_W-1:0]  rw
    );
        localparam int PROD_W = ROW_W + RW_W + 1;
        logic [PROD_W-1:0] p;
        p = PROD_W'(r) * PROD_W'(rw) + PROD_W'(w);
        return ADDR_W'(p);
    endfunction

    function automatic logic [OFF_W-1:0] lowest_set(input logic [WORD_BITS-1:0] w);
        logic [WORD_BITS-1:0] iso;
        logic [OFF_W-1:0]     idx;
        iso = w & (~w + WORD_BITS'(1));
        idx = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (iso[i]) begin
                idx = idx | OFF_W'(i);
            end
        end
        return idx;
    endfunction

    state_t state_reg, state_next;

    logic [RW_W-1:0]   row_words_reg;
    logic [RC_W-1:0]   row_count_reg;
    logic [RW_W-1:0]   eff_rw;
    logic [RC_W-1:0]   eff_rc;
    logic [WIR_W-1:0]  rw_m1;

    logic [DEPTH-1:0]  vld_reg, vld_next;
    logic              vld_q_reg;
    logic [ADDR_W-1:0] addr_reg, addr_next, rd_addr, idle_addr;
    logic [ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic [WIR_W-1:0]  cur_wir_reg, cur_wir_next;
    logic [OFF_W-1:0]  cur_off_reg, cur_off_next;
    logic [REQ_W-1:0]  req_reg, req_next;

    res_t              out_reg, out_next, pend_reg, pend_next, res_now;
    logic              m_valid_reg, m_valid_next;
    logic              out_free, accept, done, go_rmw, go_scan;

    logic              ram_we;
    logic [WORD_BITS-1:0] ram_wdata, ram_rdata, word, bit_mask, masked;

    // Decode of the incoming request.
    logic [COLW_W-1:0] in_wir_raw;
    logic              in_col_ok, in_row_ok;
    logic [WIR_W-1:0]  c_wir, s_wir;
    logic [OFF_W-1:0]  c_off, s_off;
    logic [ROW_W-1:0]  s_row_start;
    logic [RW_W-1:0]   nxt_wir_w;
    logic [RC_W-1:0]   nxt_row_w;
    logic              s_end;
    logic              wir_last, row_last;

    always_comb begin
        if (row_words_reg == '0) begin
            eff_rw = RW_W'(1);
        end else if (row_words_reg > RW_W'(MAX_ROW_WORDS)) begin
            eff_rw = RW_W'(MAX_ROW_WORDS);
        end else begin
            eff_rw = row_words_reg;
        end
        if (row_count_reg == '0) begin
            eff_rc = RC_W'(1);
        end else if (row_count_reg > RC_W'(MAX_ROWS)) begin
            eff_rc = RC_W'(MAX_ROWS);
        end else begin
            eff_rc = row_count_reg;
        end
        rw_m1 = WIR_W'(eff_rw - RW_W'(1));
    end

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Start position of a search. A find next resumes one bit past the previous hit,
    // with a column beyond the row taken as the row's last column.
    always_comb begin
        in_wir_raw  = s_col[COL_W-1:OFF_W];
        in_col_ok   = RW_W'(in_wir_raw) < eff_rw;
        in_row_ok   = RC_W'(s_row) < eff_rc;
        c_wir       = in_col_ok ? WIR_W'(in_wir_raw) : rw_m1;
        c_off       = in_col_ok ? s_col[OFF_W-1:0] : '1;
        nxt_wir_w   = RW_W'(c_wir) + RW_W'(1);
        nxt_row_w   = RC_W'(s_row) + RC_W'(1);
        s_row_start = s_row;
        s_wir       = c_wir;
        s_off       = '0;
        s_end       = 1'b0;
        if (req_t'(s_req_type) == REQ_FIND_FIRST) begin
            s_row_start = '0;
            s_wir       = '0;
        end else if (!in_row_ok) begin
            s_end = 1'b1;
        end else if (c_off != '1) begin
            s_off = c_off + OFF_W'(1);
        end else if (nxt_wir_w != eff_rw) begin
            s_wir = WIR_W'(nxt_wir_w);
        end else begin
            s_row_start = ROW_W'(nxt_row_w);
            s_wir       = '0;
            s_end       = (nxt_row_w == eff_rc);
        end
    end

    always_comb begin
        if (s_req_type inside {REQ_FIND_NEXT, REQ_FIND_FIRST}) begin
            idle_addr = word_addr(s_row_start, s_wir, eff_rw);
        end else begin
            idle_addr = word_addr(s_row, WIR_W'(in_wir_raw), eff_rw);
        end
    end

    assign rd_addr = (state_reg == ST_IDLE) ? idle_addr : addr_reg + ADDR_W'(1);

    gbfns_ram #(
        .WIDTH(WORD_BITS),
        .DEPTH(DEPTH)
    ) u_bitmap (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(addr_reg),
        .wdata(ram_wdata),
        .raddr(rd_addr),
        .rdata(ram_rdata)
    );

    // A word never written since the last clear reads as zero.
    assign word     = vld_q_reg ? ram_rdata : '0;
    assign bit_mask = WORD_BITS'(1) << cur_off_reg;
    assign masked   = word & ({WORD_BITS{1'b1}} << cur_off_reg);
    assign wir_last = (RW_W'(cur_wir_reg) + RW_W'(1)) == eff_rw;
    assign row_last = (RC_W'(cur_row_reg) + RC_W'(1)) == eff_rc;

    // Datapath and control outputs.
    always_comb begin
        vld_next     = vld_reg;
        addr_next    = addr_reg;
        cur_row_next = cur_row_reg;
        cur_wir_next = cur_wir_reg;
        cur_off_next = cur_off_reg;
        req_next     = req_reg;
        ram_we       = 1'b0;
        ram_wdata    = word;
        res_now      = '0;
        done         = 1'b0;
        go_rmw       = 1'b0;
        go_scan      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    req_next  = s_req_type;
                    addr_next = idle_addr;
                    case (req_t'(s_req_type))
                        REQ_CLEAR_ALL: begin
                            vld_next = '0;
                            done     = 1'b1;
                        end
                        REQ_SET_BIT, REQ_CLEAR_BIT, REQ_TEST_BIT: begin
                            cur_off_next = s_col[OFF_W-1:0];
                            if (in_col_ok && in_row_ok) begin
                                go_rmw = 1'b1;
                            end else begin
                                done = 1'b1;
                            end
                        end
                        REQ_FIND_NEXT, REQ_FIND_FIRST: begin
                            cur_row_next = s_row_start;
                            cur_wir_next = s_wir;
                            cur_off_next = s_off;
                            if (s_end) begin
                                res_now.at_end = 1'b1;
                                done           = 1'b1;
                            end else begin
                                go_scan = 1'b1;
                            end
                        end
                        default: begin
                            done = 1'b1;
                        end
                    endcase
                end
            end
            ST_RMW: begin
                done = 1'b1;
                case (req_t'(req_reg))
                    REQ_SET_BIT: begin
                        ram_we             = 1'b1;
                        ram_wdata          = word | bit_mask;
                        vld_next[addr_reg] = 1'b1;
                    end
                    REQ_CLEAR_BIT: begin
                        ram_we             = 1'b1;
                        ram_wdata          = word & ~bit_mask;
                        vld_next[addr_reg] = 1'b1;
                    end
                    default: begin
                        res_now.hit = |(word & bit_mask);
                    end
                endcase
            end
            ST_SCAN: begin
                if (|masked) begin
                    done              = 1'b1;
                    res_now.hit       = 1'b1;
                    res_now.found_col = COL_W'({cur_wir_reg, lowest_set(masked)});
                    res_now.found_row = cur_row_reg;
                end else if (wir_last && row_last) begin
                    done           = 1'b1;
                    res_now.at_end = 1'b1;
                end else begin
                    addr_next    = addr_reg + ADDR_W'(1);
                    cur_off_next = '0;
                    if (wir_last) begin
                        cur_wir_next = '0;
                        cur_row_next = cur_row_reg + ROW_W'(1);
                    end else begin
                        cur_wir_next = cur_wir_reg + WIR_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (go_rmw) begin
                    state_next = ST_RMW;
                end else if (go_scan) begin
                    state_next = ST_SCAN;
                end else if (done && !out_free) begin
                    state_next = ST_HOLD;
                end
            end
            ST_RMW, ST_SCAN: begin
                if (done) begin
                    state_next = out_free ? ST_IDLE : ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result register, with a holding slot while the previous result is still waiting.
    always_comb begin
        out_next     = out_reg;
        pend_next    = pend_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (state_reg == ST_HOLD && out_free) begin
            out_next     = pend_reg;
            m_valid_next = 1'b1;
        end else if (done && out_free) begin
            out_next     = res_now;
            m_valid_next = 1'b1;
        end else if (done) begin
            pend_next = res_now;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            vld_reg       <= '0;
            row_words_reg <= ROW_WORDS_RESET;
            row_count_reg <= ROW_COUNT_RESET;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            vld_reg     <= vld_next;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_ROW_WORDS: row_words_reg <= cfg_data[RW_W-1:0];
                    CFG_ROW_COUNT: row_count_reg <= cfg_data[RC_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        vld_q_reg   <= vld_reg[rd_addr];
        addr_reg    <= addr_next;
        cur_row_reg <= cur_row_next;
        cur_wir_reg <= cur_wir_next;
        cur_off_reg <= cur_off_next;
        req_reg     <= req_next;
        out_reg     <= out_next;
        pend_reg    <= pend_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_hit       = out_reg.hit;
    assign m_found_col = out_reg.found_col;
    assign m_found_row = out_reg.found_row;
    assign m_at_end    = out_reg.at_end;

    `GBFNS_ASSERT_NOW(a_write_only_in_rmw, ram_we, state_reg == ST_RMW, "bitmap written outside read-modify-write")
    `GBFNS_ASSERT_NOW(a_hit_xor_end, m_valid_reg, !(out_reg.hit && out_reg.at_end), "result has both hit and end")
    `GBFNS_ASSERT_NOW(a_end_zero_pos, m_valid_reg && out_reg.at_end, out_reg.found_col == '0 && out_reg.found_row == '0, "end result carries a position")
    `GBFNS_ASSERT_NOW(a_found_row_in_map, m_valid_reg && out_reg.hit && (req_t'(req_reg) != REQ_TEST_BIT), RC_W'(out_reg.found_row) < eff_rc, "found row outside the map")
    `GBFNS_ASSERT_NEXT(a_clear_all, accept && req_t'(s_req_type) == REQ_CLEAR_ALL, vld_reg == '0, "clear all left a valid word")

endmodule

`default_nettype wire

// ===== test/tb_grid_bitmap_find_next_set.sv =====
`timescale 1ns / 100ps

module tb_grid_bitmap_find_next_set;
    import gbfns_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED_6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_UNUSED_7 = 3'd7;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int NUM_PHASES      = 8;
    localparam int LONG_HOLD       = 400;
    localparam int TAIL_CYCLES     = 300;

    localparam res_t ANS_ZERO = '0;
    localparam res_t ANS_END  = res_t'{1'b0, 7'd0, 5'd0, 1'b1};

    typedef struct {
        logic [REQ_W-1:0] req;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        bit               typed;
        res_t             answer;
    } dir_row_t;

    // Default shape after reset: two words per row, 25 rows, so 64 columns.
    dir_row_t directed_rows [25] = '{
        '{REQ_FIND_FIRST, 7'd0,   5'd0,  1'b1, ANS_END},
        '{REQ_TEST_BIT,   7'd0,   5'd0,  1'b1, ANS_ZERO},
        '{REQ_SET_BIT,    7'd0,   5'd0,  1'b1, ANS_ZERO},
        '{REQ_TEST_BIT,   7'd0,   5'd0,  1'b1, res_t'{1'b1, 7'd0, 5'd0, 1'b0}},
        '{REQ_FIND_FIRST, 7'd0,   5'd0,  1'b1, res_t'{1'b1, 7'd0, 5'd0, 1'b0}},
        '{REQ_SET_BIT,    7'd63,  5'd24, 1'b1, ANS_ZERO},
        '{REQ_FIND_NEXT,  7'd0,   5'd0,  1'b1, res_t'{1'b1, 7'd63, 5'd24, 1'b0}},
        '{REQ_FIND_NEXT,  7'd63,  5'd24, 1'b1, ANS_END},
        '{REQ_SET_BIT,    7'd64,  5'd0,  1'b1, ANS_ZERO},
        '{REQ_TEST_BIT,   7'd64,  5'd0,  1'b1, ANS_ZERO},
        '{REQ_SET_BIT,    7'd5,   5'd25, 1'b1, ANS_ZERO},
        '{REQ_TEST_BIT,   7'd5,   5'd25, 1'b1, ANS_ZERO},
        '{REQ_FIND_NEXT,  7'd127, 5'd0,  1'b0, ANS_ZERO},
        '{REQ_FIND_NEXT,  7'd0,   5'd31, 1'b1, ANS_END},
        '{REQ_UNUSED_6,   7'd127, 5'd31, 1'b1, ANS_ZERO},
        '{REQ_UNUSED_7,   7'd127, 5'd31, 1'b1, ANS_ZERO},
        '{REQ_SET_BIT,    7'd31,  5'd3,  1'b1, ANS_ZERO},
        '{REQ_SET_BIT,    7'd32,  5'd3,  1'b1, ANS_ZERO},
        '{REQ_FIND_NEXT,  7'd31,  5'd3,  1'b0, ANS_ZERO},
        '{REQ_CLEAR_BIT,  7'd0,   5'd0,  1'b1, ANS_ZERO},
        '{REQ_FIND_FIRST, 7'd0,   5'd0,  1'b0, ANS_ZERO},
        '{REQ_CLEAR_ALL,  7'd127, 5'd31, 1'b1, ANS_ZERO},
        '{REQ_FIND_FIRST, 7'd0,   5'd0,  1'b1, ANS_END},
        '{REQ_TEST_BIT,   7'd63,  5'd24, 1'b1, ANS_ZERO},
        '{REQ_TEST_BIT,   7'd127, 5'd31, 1'b1, ANS_ZERO}
    };

    // Shapes per phase; several are out of range and must saturate.
    int phase_row_words [NUM_PHASES] = '{1, 4, 0, 7, 3, 4, 2, 5};
    int phase_row_count [NUM_PHASES] = '{1, 32, 0, 63, 17, 32, 25, 40};

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_valid;
    logic                  s_ready;
    logic [REQ_W-1:0]      s_req_type;
    logic [COL_W-1:0]      s_col;
    logic [ROW_W-1:0]      s_row;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_hit;
    logic [COL_W-1:0]      m_found_col;
    logic [ROW_W-1:0]      m_found_row;
    logic                  m_at_end;

    logic [WORD_BITS-1:0] map_words [DEPTH];
    logic [RW_W-1:0]      row_words_setting = ROW_WORDS_RESET;
    logic [RC_W-1:0]      row_count_setting = ROW_COUNT_RESET;

    res_t pending_answers [$];
    int   mismatch_count = 0;
    int   answers_seen   = 0;
    int   requests_sent  = 0;
    int   finds_hit      = 0;
    int   finds_at_end   = 0;
    int   cycle_count    = 0;
    int   src_idle_pct   = 27;
    int   sink_idle_pct  = 27;
    int   stall_request  = 0;

    bit               last_find_hit = 1'b0;
    logic [COL_W-1:0] last_find_col = '0;
    logic [ROW_W-1:0] last_find_row = '0;

    grid_bitmap_find_next_set u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_col       (s_col),
        .s_row       (s_row),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_hit       (m_hit),
        .m_found_col (m_found_col),
        .m_found_row (m_found_row),
        .m_at_end    (m_at_end)
    );

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    function automatic int eff_row_words();
        if (row_words_setting == 0) return 1;
        if (row_words_setting > MAX_ROW_WORDS) return MAX_ROW_WORDS;
        return int'(row_words_setting);
    endfunction

    function automatic int eff_row_count();
        if (row_count_setting == 0) return 1;
        if (row_count_setting > MAX_ROWS) return MAX_ROWS;
        return int'(row_count_setting);
    endfunction

    // Applies one request to the shadow bitmap and returns the answer it should give.
    function automatic res_t bitmap_apply(input logic [REQ_W-1:0] req,
                                          input logic [COL_W-1:0] col,
                                          input logic [ROW_W-1:0] row);
        int   rw;
        int   rc;
        int   c;
        int   r;
        int   row_bits;
        int   total;
        int   start;
        int   pos;
        int   idx;
        res_t ans;
        rw       = eff_row_words();
        rc       = eff_row_count();
        c        = int'(col);
        r        = int'(row);
        row_bits = rw * WORD_BITS;
        total    = rc * row_bits;
        ans      = '0;
        pos      = -1;
        case (req)
            REQ_CLEAR_ALL: begin
                foreach (map_words[i]) map_words[i] = '0;
            end
            REQ_SET_BIT, REQ_CLEAR_BIT, REQ_TEST_BIT: begin
                if (c < row_bits && r < rc) begin
                    idx = r * rw + c / WORD_BITS;
                    if (req == REQ_SET_BIT) begin
                        map_words[idx][c % WORD_BITS] = 1'b1;
                    end else if (req == REQ_CLEAR_BIT) begin
                        map_words[idx][c % WORD_BITS] = 1'b0;
                    end else begin
                        ans.hit = map_words[idx][c % WORD_BITS];
                    end
                end
            end
            REQ_FIND_NEXT, REQ_FIND_FIRST: begin
                if (req == REQ_FIND_FIRST) begin
                    start = 0;
                end else if (r >= rc) begin
                    start = total;
                end else begin
                    // A column past the row resumes the search at the next row.
                    start = r * row_bits + ((c < row_bits) ? c : row_bits - 1) + 1;
                end
                for (int b = start; b < total && pos < 0; b++) begin
                    if (map_words[b / WORD_BITS][b % WORD_BITS]) pos = b;
                end
                if (pos >= 0) begin
                    ans.hit       = 1'b1;
                    ans.found_row = ROW_W'(pos / row_bits);
                    ans.found_col = COL_W'(pos % row_bits);
                    finds_hit++;
                end else begin
                    ans.at_end = 1'b1;
                    finds_at_end++;
                end
                last_find_hit = ans.hit;
                last_find_col = ans.found_col;
                last_find_row = ans.found_row;
            end
            default: begin
            end
        endcase
        return ans;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("mismatch on answer %0d: %s is %0d, expected %0d",
                 answers_seen, what, got, want);
    endtask

    // Returns at the edge that accepted the item; valid stays up until the next call.
    task automatic offer_request(input logic [REQ_W-1:0] req, input logic [COL_W-1:0] col,
                                 input logic [ROW_W-1:0] row, input bit typed,
                                 input res_t typed_answer);
        res_t predicted;
        @(negedge aclk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid    = 1'b1;
        s_req_type = req;
        s_col      = col;
        s_row      = row;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = bitmap_apply(req, col, row);
        pending_answers.push_back(typed ? typed_answer : predicted);
        requests_sent++;
    endtask

    task automatic wait_all_answered();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_answers.size() != 0) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_index = index;
        cfg_data  = data;
        @(negedge aclk);
        cfg_we = 1'b0;
        if (index == CFG_ROW_WORDS) begin
            row_words_setting = data[RW_W-1:0];
        end else begin
            row_count_setting = data[RC_W-1:0];
        end
    endtask

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d answers outstanding",
                     cycle_count, pending_answers.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result side: random backpressure, plus one long hold when asked for.
    initial begin
        int hold_left;
        hold_left = 0;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_request > 0) begin
                hold_left     = stall_request;
                stall_request = 0;
            end
            if (hold_left > 0) begin
                m_ready = 1'b0;
                hold_left--;
            end else begin
                m_ready = ($urandom_range(0, 99) >= sink_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_answers.size() == 0) begin
                report_mismatch("answer with nothing pending, hit", int'(m_hit), 0);
            end else begin
                want = pending_answers.pop_front();
                if (m_hit !== want.hit) begin
                    report_mismatch("hit", int'(m_hit), int'(want.hit));
                end
                if (m_found_col !== want.found_col) begin
                    report_mismatch("found_col", int'(m_found_col), int'(want.found_col));
                end
                if (m_found_row !== want.found_row) begin
                    report_mismatch("found_row", int'(m_found_row), int'(want.found_row));
                end
                if (m_at_end !== want.at_end) begin
                    report_mismatch("at_end", int'(m_at_end), int'(want.at_end));
                end
            end
            answers_seen++;
        end
    end

    initial begin
        int               pick;
        int               rw_e;
        int               rc_e;
        logic [REQ_W-1:0] req;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        foreach (map_words[i]) map_words[i] = '0;
        aresetn    = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        s_valid    = 1'b0;
        s_req_type = '0;
        s_col      = '0;
        s_row      = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed_rows[i]) begin
            offer_request(directed_rows[i].req, directed_rows[i].col, directed_rows[i].row,
                          directed_rows[i].typed, directed_rows[i].answer);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_all_answered();
            write_register(CFG_ROW_WORDS,
                           {3'($urandom_range(0, 7)), 3'(phase_row_words[p])});
            write_register(CFG_ROW_COUNT, CFG_DATA_W'(phase_row_count[p]));
            src_idle_pct  = (p == 5 || p == 6) ? 0 : 27;
            sink_idle_pct = (p == 6) ? 0 : 27;
            if (p == 5) begin
                // Results back up behind a long hold while requests keep coming.
                @(posedge aclk);
                stall_request = LONG_HOLD;
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                pick = $urandom_range(0, 99);
                rw_e = eff_row_words();
                rc_e = eff_row_count();
                col  = COL_W'($urandom_range(0, rw_e * WORD_BITS - 1));
                row  = ROW_W'($urandom_range(0, rc_e - 1));
                if (pick < 30) begin
                    req = REQ_SET_BIT;
                end else if (pick < 40) begin
                    req = REQ_CLEAR_BIT;
                end else if (pick < 55) begin
                    req = REQ_TEST_BIT;
                end else if (pick < 75) begin
                    // Walk the hits one after another, the way a caller would.
                    if (last_find_hit) begin
                        req = REQ_FIND_NEXT;
                        col = last_find_col;
                        row = last_find_row;
                    end else begin
                        req = REQ_FIND_FIRST;
                    end
                end else if (pick < 83) begin
                    req = REQ_FIND_FIRST;
                end else if (pick < 85) begin
                    req = REQ_CLEAR_ALL;
                end else begin
                    req = REQ_W'($urandom_range(0, 7));
                    col = COL_W'($urandom_range(0, 127));
                    row = ROW_W'($urandom_range(0, 31));
                end
                offer_request(req, col, row, 1'b0, ANS_ZERO);
            end
        end

        wait_all_answered();
        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("Sent %0d requests, first on the reset shape, then in %0d configured phases,",
                 requests_sent, NUM_PHASES);
        $display("and checked %0d answers; %0d searches found a bit, %0d ran off the end.",
                 answers_seen, finds_hit, finds_at_end);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
